// ===== hdl/rpn_pkg.sv =====
// Shared types and constants for the postfix expression evaluator.
// Token codes, status codes, sequencer states and ALU handshake structs.
// No dependencies.
`default_nettype none

package rpn_pkg;

  // Operand stack geometry
  localparam int STACK_DEPTH = 64;
  localparam int DATA_W      = 32;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int ITER_W      = $clog2(DATA_W);

  // Stream packing widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;

  // Token kinds; code seven is an invalid operator and is ignored
  typedef enum logic [2:0] {
    TOK_DIGIT = 3'd0,
    TOK_ADD   = 3'd1,
    TOK_SUB   = 3'd2,
    TOK_MUL   = 3'd3,
    TOK_DIV   = 3'd4,
    TOK_XOR   = 3'd5,
    TOK_END   = 3'd6
  } tok_t;

  // Result status, also the sticky error code
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_DIVZERO   = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  // Token sequencer
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_END
  } seq_state_t;

  // Shared ALU
  typedef enum logic [1:0] {
    A_IDLE,
    A_MUL,
    A_DIV,
    A_FIX
  } alu_state_t;

  typedef struct packed {
    logic start;
    tok_t op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic div_zero;
  } alu_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/rpn_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
`default_nettype none

module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rpn_alu.sv =====
// Shared iterative ALU: direct add/sub/xor, shift-add multiply and
// restoring divide at one bit per cycle, plus a sign fixup state.
// Depends on rpn_pkg.
`default_nettype none

module rpn_alu (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire rpn_pkg::alu_req_t        req,
  input  wire logic [rpn_pkg::DATA_W-1:0] lhs,
  input  wire logic [rpn_pkg::DATA_W-1:0] rhs,
  output rpn_pkg::alu_rsp_t             rsp,
  output logic      [rpn_pkg::DATA_W-1:0] result
);
  import rpn_pkg::*;

  alu_state_t        state_r,  state_nxt;
  logic [ITER_W-1:0] cnt_r,    cnt_nxt;
  logic [DATA_W-1:0] acc_r,    acc_nxt;   // product, or divisor magnitude
  logic [DATA_W-1:0] sh_r,     sh_nxt;    // multiplicand, or partial remainder
  logic [DATA_W-1:0] q_r,      q_nxt;     // multiplier, or dividend/quotient
  logic              neg_r,    neg_nxt;
  logic [DATA_W-1:0] res_r,    res_nxt;
  logic              done_r,   done_nxt;
  logic              dz_r,     dz_nxt;

  logic [DATA_W-1:0] mul_sum;
  logic [DATA_W:0]   trial;
  logic              fits;
  logic              last_iter;

  // datapath of the shared adder
  always_comb begin
    mul_sum   = acc_r + (q_r[0] ? sh_r : '0);
    trial     = {sh_r, q_r[DATA_W-1]} - {1'b0, acc_r};
    fits      = ~trial[DATA_W];
    last_iter = (cnt_r == ITER_W'(DATA_W - 1));
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    sh_nxt    = sh_r;
    q_nxt     = q_r;
    neg_nxt   = neg_r;
    res_nxt   = res_r;
    done_nxt  = 1'b0;
    dz_nxt    = 1'b0;
    unique case (state_r)
      A_IDLE: begin
        if (req.start) begin
          case (req.op)
            TOK_ADD: begin
              res_nxt  = lhs + rhs;
              done_nxt = 1'b1;
            end
            TOK_SUB: begin
              res_nxt  = lhs - rhs;
              done_nxt = 1'b1;
            end
            TOK_XOR: begin
              res_nxt  = lhs ^ rhs;
              done_nxt = 1'b1;
            end
            TOK_MUL: begin
              acc_nxt   = '0;
              sh_nxt    = lhs;
              q_nxt     = rhs;
              cnt_nxt   = '0;
              state_nxt = A_MUL;
            end
            TOK_DIV: begin
              if (rhs == '0) begin
                res_nxt  = '0;
                dz_nxt   = 1'b1;
                done_nxt = 1'b1;
              end else begin
                neg_nxt   = lhs[DATA_W-1] ^ rhs[DATA_W-1];
                q_nxt     = lhs[DATA_W-1] ? (DATA_W'(0) - lhs) : lhs;
                acc_nxt   = rhs[DATA_W-1] ? (DATA_W'(0) - rhs) : rhs;
                sh_nxt    = '0;
                cnt_nxt   = '0;
                state_nxt = A_DIV;
              end
            end
            default: begin
              res_nxt  = '0;
              done_nxt = 1'b1;
            end
          endcase
        end
      end
      A_MUL: begin
        acc_nxt = mul_sum;
        sh_nxt  = {sh_r[DATA_W-2:0], 1'b0};
        q_nxt   = {1'b0, q_r[DATA_W-1:1]};
        cnt_nxt = cnt_r + 1'b1;
        if (last_iter) begin
          q_nxt     = mul_sum;
          neg_nxt   = 1'b0;
          state_nxt = A_FIX;
        end
      end
      A_DIV: begin
        sh_nxt  = fits ? trial[DATA_W-1:0] : {sh_r[DATA_W-2:0], q_r[DATA_W-1]};
        q_nxt   = {q_r[DATA_W-2:0], fits};
        cnt_nxt = cnt_r + 1'b1;
        if (last_iter) begin
          state_nxt = A_FIX;
        end
      end
      A_FIX: begin
        res_nxt   = neg_r ? (DATA_W'(0) - q_r) : q_r;
        done_nxt  = 1'b1;
        state_nxt = A_IDLE;
      end
      default: state_nxt = A_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
      dz_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      dz_r    <= dz_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    q_r   <= q_nxt;
    neg_r <= neg_nxt;
    res_r <= res_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.div_zero = dz_r;
  assign result       = res_r;

  // a start is only issued while the unit is free
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> (state_r == A_IDLE))
    else $error("ALU started while busy");

  // divide-by-zero is reported only together with done
  a_dz_done: assert property (@(posedge clk) disable iff (!rst_n)
    dz_r |-> done_r)
    else $error("divide-by-zero flag without done");

  // the fixup state always ends in done and a return to idle
  a_fix_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == A_FIX) |=> (done_r && (state_r == A_IDLE)))
    else $error("fixup cycle did not complete");

endmodule

`default_nettype wire

// ===== hdl/postfix_expression_evaluator_unit.sv =====
// Postfix expression evaluator: one token per input transfer, one result per end token.
// Digits push on accept; add/sub/xor and divide by zero read the operand, compute in the
// ALU and write back; mul/div read the operand, run 32 bit-serial ALU steps, a sign fixup
// and write-back. An end token enters the end state, then its result is registered on
// out_, later while an earlier result waits. in_tready is low while an operator or end
// token runs. Top of stack lives in a register, the rest in a single RAM read on accept.
// Reset (rst_n low, synchronous): stack empty, error cleared, no result pending.
// Depends on rpn_pkg, rpn_ram, rpn_alu.
`default_nettype none

module postfix_expression_evaluator_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [rpn_pkg::IN_TDATA_W-1:0] in_tdata,   // [2:0] op, [6:3] digit_value
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic      [rpn_pkg::OUT_TDATA_W-1:0] out_tdata  // [31:0] value, [34:32] status
);
  import rpn_pkg::*;

  seq_state_t        state_r, state_nxt;
  logic [SP_W-1:0]   sp_r,    sp_nxt;
  status_t           err_r,   err_nxt;
  logic [DATA_W-1:0] tos_r,   tos_nxt;
  tok_t              op_r,    op_nxt;
  logic              ovld_r,  ovld_nxt;
  logic [DATA_W-1:0] oval_r,  oval_nxt;
  status_t           ost_r,   ost_nxt;

  tok_t              in_op;
  logic [3:0]        in_digit;
  logic              in_xfer;
  logic              out_free;
  logic [SP_W-1:0]   sp_m1;
  logic [SP_W-1:0]   sp_m2;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  logic [DATA_W-1:0] alu_result;

  assign in_op     = tok_t'(in_tdata[2:0]);
  assign in_digit  = in_tdata[6:3];
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !ovld_r || out_tready;
  assign sp_m1     = sp_r - SP_W'(1);
  assign sp_m2     = sp_r - SP_W'(2);
  assign ram_waddr = sp_m1[ADDR_W-1:0];
  assign ram_raddr = sp_m2[ADDR_W-1:0];

  // entries below the top of stack
  rpn_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (tos_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rpn_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .lhs    (ram_rdata),
    .rhs    (tos_r),
    .rsp    (alu_rsp),
    .result (alu_result)
  );

  // token sequencer
  always_comb begin
    state_nxt     = state_r;
    sp_nxt        = sp_r;
    err_nxt       = err_r;
    tos_nxt       = tos_r;
    op_nxt        = op_r;
    ovld_nxt      = ovld_r && !out_tready;
    oval_nxt      = oval_r;
    ost_nxt       = ost_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    alu_req.start = 1'b0;
    alu_req.op    = op_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_op)
            TOK_DIGIT: begin
              if (sp_r >= SP_W'(STACK_DEPTH)) begin
                if (err_r == ST_OK) err_nxt = ST_OVERFLOW;
              end else begin
                ram_we  = (sp_r != '0);
                tos_nxt = DATA_W'(in_digit);
                sp_nxt  = sp_r + SP_W'(1);
              end
            end
            TOK_END: begin
              state_nxt = S_END;
            end
            TOK_ADD, TOK_SUB, TOK_MUL, TOK_DIV, TOK_XOR: begin
              if (sp_r < SP_W'(2)) begin
                if (err_r == ST_OK) err_nxt = ST_UNDERFLOW;
              end else begin
                ram_re    = 1'b1;
                op_nxt    = in_op;
                state_nxt = S_READ;
              end
            end
            default: ;  // invalid operator: ignored
          endcase
        end
      end
      S_READ: begin
        // left operand is on the RAM read port now
        alu_req.start = 1'b1;
        state_nxt     = S_EXEC;
      end
      S_EXEC: begin
        if (alu_rsp.done) begin
          tos_nxt   = alu_result;
          sp_nxt    = sp_m1;
          if (alu_rsp.div_zero && (err_r == ST_OK)) err_nxt = ST_DIVZERO;
          state_nxt = S_IDLE;
        end
      end
      S_END: begin
        if (out_free) begin
          ovld_nxt = 1'b1;
          if (err_r != ST_OK) begin
            oval_nxt = '0;
            ost_nxt  = err_r;
          end else if (sp_r == '0) begin
            oval_nxt = '0;
            ost_nxt  = ST_EMPTY;
          end else begin
            oval_nxt = tos_r;
            ost_nxt  = ST_OK;
          end
          sp_nxt    = '0;
          err_nxt   = ST_OK;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sp_r    <= '0;
      err_r   <= ST_OK;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
      err_r   <= err_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    tos_r  <= tos_nxt;
    op_r   <= op_nxt;
    oval_r <= oval_nxt;
    ost_r  <= ost_nxt;
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = {{(OUT_TDATA_W - DATA_W - 3){1'b0}}, ost_r, oval_r};

  // stack pointer never passes the stack depth
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  // ALU completion only lands while the sequencer waits for it
  a_alu_done: assert property (@(posedge clk) disable iff (!rst_n)
    alu_rsp.done |-> (state_r == S_EXEC))
    else $error("ALU done outside execute state");

  // a new result appears only out of the end state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovld_r) |-> ($past(state_r) == S_END))
    else $error("result raised outside end state");

  // an emitted end clears the stack and the error
  a_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_END) && out_free) |=> ((sp_r == '0) && (err_r == ST_OK)))
    else $error("end token left stack or error set");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for postfix_expression_evaluator_unit: token stream in, results out.
// Predicts each end-token result from its own stack model and scoreboards it in order.
// Depends on rpn_pkg and the evaluator RTL.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rpn_pkg::*;

  // Token code seven has no name in the package; the block ignores it
  localparam logic [2:0] TOK_INVALID = 3'd7;
  localparam int HOLD_CYCLES = 1500;
  localparam int DRAIN_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic [31:0] value;
    status_t     status;
  } result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [2:0] op, [6:3] digit_value
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [31:0] value, [34:32] status

  // Predictor state
  logic [31:0] eval_stack [STACK_DEPTH];
  int unsigned eval_depth;
  status_t     eval_err;
  result_t     pending_results[$];

  int n_fail;
  int tokens_sent;
  int results_seen;
  bit calm;          // no idling on either side
  bit hold_req;      // ask the sink for one long stall
  bit sink_holding;

  postfix_expression_evaluator_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Run limit
  initial begin
    #(2_000_000);
    $display("postfix_expression_evaluator_unit verification failed");
    $finish;
  end

  // Signed divide truncating toward zero, via magnitudes
  function automatic logic [31:0] quot_trunc(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [31:0] q;
    mag_a = a[31] ? -a : a;
    mag_b = b[31] ? -b : b;
    q = mag_a / mag_b;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  // First error of an expression sticks
  function automatic void record_error(input status_t code);
    if (eval_err == ST_OK) eval_err = code;
  endfunction

  // Advance the stack model by one token; an end token queues a result
  function automatic void eval_token(input logic [2:0] op, input logic [3:0] dv);
    logic [31:0] lhs;
    logic [31:0] rhs;
    logic [31:0] r;
    result_t res;
    if (op == TOK_DIGIT) begin
      if (eval_depth >= STACK_DEPTH) begin
        record_error(ST_OVERFLOW);
      end else begin
        eval_stack[eval_depth] = {28'd0, dv};
        eval_depth++;
      end
    end else if (op == TOK_END) begin
      res.value = '0;
      if (eval_err != ST_OK) begin
        res.status = eval_err;
      end else if (eval_depth == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.value = eval_stack[eval_depth-1];
        res.status = ST_OK;
      end
      pending_results.push_back(res);
      eval_depth = 0;
      eval_err = ST_OK;
    end else if (op == TOK_INVALID) begin
      // ignored entirely
    end else if (eval_depth < 2) begin
      record_error(ST_UNDERFLOW);
    end else begin
      rhs = eval_stack[eval_depth-1];
      lhs = eval_stack[eval_depth-2];
      case (tok_t'(op))
        TOK_ADD: r = lhs + rhs;
        TOK_SUB: r = lhs - rhs;
        TOK_MUL: r = lhs * rhs;
        TOK_DIV: begin
          if (rhs == 0) begin
            record_error(ST_DIVZERO);
            r = '0;
          end else begin
            r = quot_trunc(lhs, rhs);
          end
        end
        default: r = lhs ^ rhs;
      endcase
      eval_depth--;
      eval_stack[eval_depth-1] = r;
    end
  endfunction

  // Predict on every accepted input transfer
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) eval_token(in_tdata[2:0], in_tdata[6:3]);
  end

  // Compare every accepted result with the oldest prediction
  always @(posedge clk) begin : result_check
    result_t want;
    logic [31:0] got_value;
    logic [2:0] got_status;
    if (rst_n && out_tvalid && out_tready) begin
      got_value = out_tdata[31:0];
      got_status = out_tdata[34:32];
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: value %0d status %0d", $signed(got_value), got_status);
        n_fail++;
      end else begin
        want = pending_results.pop_front();
        if (got_value !== want.value) begin
          $error("value: expected %0d, got %0d", $signed(want.value), $signed(got_value));
          n_fail++;
        end
        if (got_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got_status);
          n_fail++;
        end
      end
    end
  end

  // Result sink: random stalls, one long hold on request, none when calm
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        sink_holding = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        sink_holding = 1'b0;
      end else if (calm) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // One input transfer, then maybe an idle burst
  task automatic send_token(input logic [2:0] op, input logic [3:0] dv);
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, dv, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tokens_sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic send_digit(input logic [3:0] dv);
    send_token(TOK_DIGIT, dv);
  endtask

  // Non-digit token with junk in the digit field
  task automatic send_op(input logic [2:0] op);
    send_token(op, 4'($urandom_range(0, 15)));
  endtask

  // Operator mix biased toward multiply so values grow and wrap
  function automatic tok_t pick_operator();
    case ($urandom_range(0, 9))
      0, 1:    return TOK_ADD;
      2, 3:    return TOK_SUB;
      4, 5, 6: return TOK_MUL;
      7:       return TOK_DIV;
      default: return TOK_XOR;
    endcase
  endfunction

  // One random expression; noisy ones get stray, invalid or missing tokens
  task automatic send_random_expr(input int max_len, input bit noisy);
    int depth;
    int len;
    depth = 0;
    len = $urandom_range(1, max_len);
    if (noisy && $urandom_range(0, 9) == 0) len = 0;
    for (int i = 0; i < len; i++) begin
      if (noisy && $urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 1) == 0) begin
          send_op(TOK_INVALID);
        end else begin
          send_op(pick_operator());
          if (depth >= 2) depth--;
        end
      end else if (depth < 2 || $urandom_range(0, 4) < 2) begin
        send_digit(4'($urandom_range(0, 15)));
        depth++;
      end else begin
        send_op(pick_operator());
        depth--;
      end
    end
    // reduce to one entry, unless a noisy run leaves leftovers
    if (!(noisy && $urandom_range(0, 2) == 0)) begin
      while (depth > 1) begin
        send_op(pick_operator());
        depth--;
      end
    end
    send_op(TOK_END);
  endtask

  // Every operator, digit extremes, empty end, sticky errors, invalid tokens
  task automatic test_directed();
    send_op(TOK_END);
    send_digit(3); send_digit(4); send_op(TOK_SUB);
    send_digit(15); send_digit(15); send_op(TOK_MUL);
    send_op(TOK_ADD); send_op(TOK_END);
    send_digit(9); send_digit(2); send_op(TOK_DIV);
    send_digit(12); send_op(TOK_XOR); send_op(TOK_END);
    send_digit(5); send_digit(0); send_op(TOK_DIV); send_op(TOK_END);
    // underflow first, then divide by zero: the first error wins
    send_op(TOK_ADD); send_digit(5); send_digit(0); send_op(TOK_DIV); send_op(TOK_END);
    // invalid codes ignored, extra entry left on the stack
    send_op(TOK_INVALID); send_digit(1); send_digit(2); send_op(TOK_INVALID);
    send_op(TOK_END);
  endtask

  // Signed divide: most negative by minus one, and truncation of negatives
  task automatic test_divide_corners();
    send_digit(2);
    repeat (10) begin
      send_digit(8);
      send_op(TOK_MUL);
    end
    send_digit(0); send_digit(1); send_op(TOK_SUB);
    send_op(TOK_DIV); send_op(TOK_END);
    send_digit(7); send_digit(0); send_digit(1); send_op(TOK_SUB);
    send_op(TOK_DIV); send_op(TOK_END);
    send_digit(0); send_digit(7); send_op(TOK_SUB); send_digit(2);
    send_op(TOK_DIV); send_op(TOK_END);
  endtask

  // Fill the stack exactly, reduce it; then push past full
  task automatic test_stack_limits();
    repeat (STACK_DEPTH) send_digit(4'($urandom_range(0, 15)));
    repeat (STACK_DEPTH - 1) send_op(pick_operator());
    send_op(TOK_END);
    repeat (STACK_DEPTH + 2) send_digit(4'($urandom_range(0, 15)));
    send_op(TOK_ADD);
    send_op(TOK_END);
  endtask

  // Sink holds off while expressions keep coming, so the input stalls
  task automatic test_backpressure();
    hold_req = 1'b1;
    wait (sink_holding);
    repeat (5) send_random_expr(4, 1'b0);
  endtask

  task automatic test_random(input int token_target);
    while (tokens_sent < token_target) send_random_expr(12, $urandom_range(0, 3) == 0);
  endtask

  initial begin
    int drain;
    n_fail = 0;
    tokens_sent = 0;
    results_seen = 0;
    calm = 1'b0;
    hold_req = 1'b0;
    sink_holding = 1'b0;
    eval_depth = 0;
    eval_err = ST_OK;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_divide_corners();
    test_stack_limits();
    test_backpressure();
    test_random(490);
    calm = 1'b1;
    test_random(550);
    in_tvalid <= 1'b0;

    // drain, then allow the longest token to finish
    drain = 0;
    while (pending_results.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      n_fail++;
    end

    $display("Sent %0d tokens and checked %0d results: all operators, digits 0-15, invalid codes,",
             tokens_sent, results_seen);
    $display("underflow, divide by zero, stack full and overflow, signed divide corners, long stall.");
    if (n_fail == 0) begin
      $display("postfix_expression_evaluator_unit verification clean");
    end else begin
      $display("postfix_expression_evaluator_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/rpn_pkg.sv
hdl/rpn_ram.sv
hdl/rpn_alu.sv
hdl/postfix_expression_evaluator_unit.sv
bench/testbench.sv
